FILE: sv/amacc_pkg.sv
// Shared types and constants of the angular momentum accumulator.
`default_nettype none

package amacc_pkg;

    // fixed field widths of the particle and result transactions
    localparam int unsigned FIELD_W   = 32;
    localparam int unsigned D_W       = FIELD_W + 1;
    localparam int unsigned HALF_W    = FIELD_W / 2;
    localparam int unsigned OUT_W     = 48;

    // depths of the command and result queues
    localparam int unsigned CMD_DEPTH = 2;
    localparam int unsigned RES_DEPTH = 2;

    // register indexes of the configuration port, one word apart
    typedef enum logic [1:0] {
        REG_ORIGIN_X,
        REG_ORIGIN_Y,
        REG_ORIGIN_Z,
        REG_GROUP_SELECT
    } t_reg_idx;

    // classified particle handed from the front end to the back end
    typedef struct packed {
        logic signed [D_W-1:0]     d_x;
        logic signed [D_W-1:0]     d_y;
        logic signed [D_W-1:0]     d_z;
        logic signed [FIELD_W-1:0] v_x;
        logic signed [FIELD_W-1:0] v_y;
        logic signed [FIELD_W-1:0] v_z;
        logic [FIELD_W-1:0]        mass;
        logic                      counted;
        logic                      last;
    } t_cmd;

    // one emitted set of sums
    typedef struct packed {
        logic signed [OUT_W-1:0] mom_x;
        logic signed [OUT_W-1:0] mom_y;
        logic signed [OUT_W-1:0] mom_z;
        logic                    overflowed;
    } t_res;

endpackage

`default_nettype wire

FILE: sv/angular_momentum_accumulator_top.sv
// Top level of the angular momentum accumulator: register port, queues, front and back ends.
//
// Sums m * ((pos - origin) x vel) over the particles whose member mask meets the
// group select register, in Q16.16 with floor rounding after each product and
// saturating accumulators, and emits the three sums with an overflow flag on the
// particle marked last, clearing them afterwards. A particle that is neither in the
// group nor last is dropped at the input and never reaches the back end. A counted
// particle is taken in the idle state, then runs 36 steps through the back end's single
// 34-by-17-bit multiplier and accumulator pipeline (twelve half-products for the
// cross terms, twelve for the mass scaling, plus the floor, clamp and sum steps),
// then a drain step. A set closes in the emit state, entered from the drain step or,
// for a last particle outside the group, from the idle state, once the result queue
// has room. A two-entry command queue lets the input take particles while the back
// end works, and a two-entry result queue decouples the output.
`default_nettype none

module angular_momentum_accumulator_top #(
    parameter int ACC_WIDTH = 48,
    parameter int FRAC_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // particle transactions
    input  logic                                  push,
    output logic                                  full,
    input  logic signed [amacc_pkg::FIELD_W-1:0]  i_pos_x,
    input  logic signed [amacc_pkg::FIELD_W-1:0]  i_pos_y,
    input  logic signed [amacc_pkg::FIELD_W-1:0]  i_pos_z,
    input  logic signed [amacc_pkg::FIELD_W-1:0]  i_vel_x,
    input  logic signed [amacc_pkg::FIELD_W-1:0]  i_vel_y,
    input  logic signed [amacc_pkg::FIELD_W-1:0]  i_vel_z,
    input  logic        [amacc_pkg::FIELD_W-1:0]  i_particle_mass,
    input  logic        [amacc_pkg::FIELD_W-1:0]  i_member_mask,
    input  logic                                  i_last_particle,
    // result transactions
    output logic                                  empty,
    input  logic                                  pop,
    output logic signed [amacc_pkg::OUT_W-1:0]    o_momentum_x,
    output logic signed [amacc_pkg::OUT_W-1:0]    o_momentum_y,
    output logic signed [amacc_pkg::OUT_W-1:0]    o_momentum_z,
    output logic                                  o_overflowed,
    // register port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [3:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    logic signed [amacc_pkg::FIELD_W-1:0] r_origin_x;
    logic signed [amacc_pkg::FIELD_W-1:0] r_origin_y;
    logic signed [amacc_pkg::FIELD_W-1:0] r_origin_z;
    logic [amacc_pkg::FIELD_W-1:0]        r_group_select;

    logic [1:0]      w_reg_idx;
    logic            w_reg_wr;
    amacc_pkg::t_cmd w_cmd_in;
    amacc_pkg::t_cmd w_cmd_out;
    logic            w_cmd_push;
    logic            w_cmd_full;
    logic            w_cmd_pop;
    logic            w_cmd_empty;
    amacc_pkg::t_res w_res_in;
    amacc_pkg::t_res w_res_out;
    logic            w_res_push;
    logic            w_res_full;

    // register port: zero wait states
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[3:2];
    assign w_reg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x     <= '0;
            r_origin_y     <= '0;
            r_origin_z     <= '0;
            r_group_select <= 32'd1;
        end else if (w_reg_wr) begin
            case (w_reg_idx)
                amacc_pkg::REG_ORIGIN_X:     r_origin_x     <= pwdata;
                amacc_pkg::REG_ORIGIN_Y:     r_origin_y     <= pwdata;
                amacc_pkg::REG_ORIGIN_Z:     r_origin_z     <= pwdata;
                amacc_pkg::REG_GROUP_SELECT: r_group_select <= pwdata;
                default:                     r_group_select <= r_group_select;
            endcase
        end
    end

    // read back
    always_comb begin
        case (w_reg_idx)
            amacc_pkg::REG_ORIGIN_X:     prdata = r_origin_x;
            amacc_pkg::REG_ORIGIN_Y:     prdata = r_origin_y;
            amacc_pkg::REG_ORIGIN_Z:     prdata = r_origin_z;
            amacc_pkg::REG_GROUP_SELECT: prdata = r_group_select;
            default:                     prdata = '0;
        endcase
    end

    // front end
    amacc_front u_front (
        .i_push          (push),
        .o_full          (full),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_pos_z         (i_pos_z),
        .i_vel_x         (i_vel_x),
        .i_vel_y         (i_vel_y),
        .i_vel_z         (i_vel_z),
        .i_particle_mass (i_particle_mass),
        .i_member_mask   (i_member_mask),
        .i_last_particle (i_last_particle),
        .i_origin_x      (r_origin_x),
        .i_origin_y      (r_origin_y),
        .i_origin_z      (r_origin_z),
        .i_group_select  (r_group_select),
        .i_q_full        (w_cmd_full),
        .o_cmd           (w_cmd_in),
        .o_cmd_push      (w_cmd_push)
    );

    // command queue between front and back
    amacc_queue #(
        .WIDTH ($bits(amacc_pkg::t_cmd)),
        .DEPTH (amacc_pkg::CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_data  (w_cmd_in),
        .o_full  (w_cmd_full),
        .i_pop   (w_cmd_pop),
        .o_data  (w_cmd_out),
        .o_empty (w_cmd_empty)
    );

    // back end
    amacc_back #(
        .ACC_WIDTH (ACC_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd_out),
        .i_cmd_valid (!w_cmd_empty),
        .o_cmd_pop   (w_cmd_pop),
        .o_res       (w_res_in),
        .o_res_push  (w_res_push),
        .i_res_full  (w_res_full)
    );

    // result queue
    amacc_queue #(
        .WIDTH ($bits(amacc_pkg::t_res)),
        .DEPTH (amacc_pkg::RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_out),
        .o_empty (empty)
    );

    assign o_momentum_x = w_res_out.mom_x;
    assign o_momentum_y = w_res_out.mom_y;
    assign o_momentum_z = w_res_out.mom_z;
    assign o_overflowed = w_res_out.overflowed;

`ifndef SYNTHESIS
    // back end never pushes a result into a full queue
    a_res_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> !w_res_full)
        else $error("result pushed into full queue");

    // front end never pushes a command into a full queue
    a_cmd_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_push |-> !w_cmd_full)
        else $error("command pushed into full queue");

    // back end only takes a command that is there
    a_cmd_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> !w_cmd_empty)
        else $error("command popped from empty queue");
`endif

endmodule

`default_nettype wire

FILE: sv/amacc_queue.sv
// Small first-in first-out queue built from registers.
`default_nettype none

module amacc_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_data    = r_mem[r_rd];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: sv/amacc_front.sv
// Front end: takes particles, checks group membership, forms offsets from the origin.
`default_nettype none

module amacc_front (
    input  logic                                  i_push,
    output logic                                  o_full,
    input  logic signed [amacc_pkg::FIELD_W-1:0]  i_pos_x,
    input  logic signed [amacc_pkg::FIELD_W-1:0]  i_pos_y,
    input  logic signed [amacc_pkg::FIELD_W-1:0]  i_pos_z,
    input  logic signed [amacc_pkg::FIELD_W-1:0]  i_vel_x,
    input  logic signed [amacc_pkg::FIELD_W-1:0]  i_vel_y,
    input  logic signed [amacc_pkg::FIELD_W-1:0]  i_vel_z,
    input  logic        [amacc_pkg::FIELD_W-1:0]  i_particle_mass,
    input  logic        [amacc_pkg::FIELD_W-1:0]  i_member_mask,
    input  logic                                  i_last_particle,
    input  logic signed [amacc_pkg::FIELD_W-1:0]  i_origin_x,
    input  logic signed [amacc_pkg::FIELD_W-1:0]  i_origin_y,
    input  logic signed [amacc_pkg::FIELD_W-1:0]  i_origin_z,
    input  logic        [amacc_pkg::FIELD_W-1:0]  i_group_select,
    input  logic                                  i_q_full,
    output amacc_pkg::t_cmd                       o_cmd,
    output logic                                  o_cmd_push
);

    logic w_in_group;

    // a particle counts when it shares a bit with the selected group
    assign w_in_group = |(i_member_mask & i_group_select);

    // offsets are exact at one bit wider than the fields
    always_comb begin
        o_cmd.d_x     = amacc_pkg::D_W'(i_pos_x) - amacc_pkg::D_W'(i_origin_x);
        o_cmd.d_y     = amacc_pkg::D_W'(i_pos_y) - amacc_pkg::D_W'(i_origin_y);
        o_cmd.d_z     = amacc_pkg::D_W'(i_pos_z) - amacc_pkg::D_W'(i_origin_z);
        o_cmd.v_x     = i_vel_x;
        o_cmd.v_y     = i_vel_y;
        o_cmd.v_z     = i_vel_z;
        o_cmd.mass    = i_particle_mass;
        o_cmd.counted = w_in_group;
        o_cmd.last    = i_last_particle;
    end

    // particles that neither count nor close the set are dropped here
    assign o_full     = i_q_full;
    assign o_cmd_push = i_push && !i_q_full && (w_in_group || i_last_particle);

endmodule

`default_nettype wire

FILE: sv/amacc_back.sv
// Back end: cross product and mass scaling on one shared multiplier, saturating sums.
`default_nettype none

module amacc_back #(
    parameter int ACC_WIDTH = 48,
    parameter int FRAC_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  amacc_pkg::t_cmd i_cmd,
    input  logic            i_cmd_valid,
    output logic            o_cmd_pop,
    output amacc_pkg::t_res o_res,
    output logic            o_res_push,
    input  logic            i_res_full
);

    localparam int FW  = amacc_pkg::FIELD_W;
    localparam int HW  = amacc_pkg::HALF_W;
    localparam int DW  = amacc_pkg::D_W;
    localparam int OW  = amacc_pkg::OUT_W;
    // cross term width, multiplier operand widths, accumulator width
    localparam int CW  = 2 * FW + 2 - FRAC_BITS;
    localparam int MA  = (CW - HW > DW) ? CW - HW : DW;
    localparam int MB  = HW + 1;
    localparam int PW  = MA + MB;
    localparam int AW  = CW + FW + 1;
    localparam int EW  = (ACC_WIDTH > OW) ? ACC_WIDTH : OW;

    localparam logic [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
    localparam logic [OW-1:0]        OUT_MAX = {1'b0, {(OW-1){1'b1}}};
    localparam logic [OW-1:0]        OUT_MIN = {1'b1, {(OW-1){1'b0}}};

    localparam logic [2:0] SUB_CROSS_LAST = 3'd2;
    localparam logic [2:0] SUB_MASS_LAST  = 3'd5;
    localparam logic [2:0] IDX_CROSS_LAST = 3'd5;
    localparam logic [2:0] IDX_MASS_LAST  = 3'd2;

    typedef enum logic [2:0] {S_IDLE, S_CROSS, S_MASS, S_DRAIN, S_EMIT} t_state;
    typedef enum logic [2:0] {
        OP_NOP, OP_LOAD, OP_ADD, OP_T1, OP_C, OP_CLAMP, OP_SUM
    } t_op;
    typedef enum logic [1:0] {SH_NONE, SH_HALF, SH_FULL} t_shift;

    t_state                 r_state;
    logic [2:0]             r_idx;
    logic [2:0]             r_sub;
    amacc_pkg::t_cmd        r_cmd;

    logic signed [DW-1:0]   sel_d;
    logic signed [FW-1:0]   sel_v;
    logic signed [CW-1:0]   sel_c;
    t_op                    s1_op;
    t_shift                 s1_shift;
    logic [1:0]             s1_axis;
    logic signed [MA-1:0]   s1_a;
    logic signed [MB-1:0]   s1_b;

    logic signed [PW-1:0]   r_prod;
    t_op                    r_op;
    t_shift                 r_shift;
    logic [1:0]             r_axis;

    logic signed [AW-1:0]   r_acc;
    logic signed [CW-1:0]   r_t1;
    logic signed [CW-1:0]   r_c [3];
    logic [ACC_WIDTH-1:0]   r_term;
    logic signed [ACC_WIDTH-1:0] r_sum [3];
    logic                   r_sat;

    logic signed [AW-1:0]   prod_ext;
    logic signed [AW-1:0]   prod_sh;
    logic signed [AW-1:0]   acc_q;
    logic [AW-ACC_WIDTH:0]  q_hi;
    logic                   q_fits;
    logic [ACC_WIDTH-1:0]   n_term;
    logic signed [CW-1:0]   n_c;
    logic signed [ACC_WIDTH-1:0] sum_cur;
    logic [ACC_WIDTH:0]     sum_wide;
    logic                   sum_ovf;
    logic [ACC_WIDTH-1:0]   n_sum;

    logic signed [EW-1:0]   emit_se  [3];
    logic [EW-OW:0]         emit_hi  [3];
    logic [OW-1:0]          emit_val [3];
    logic [2:0]             emit_clip;
    logic                   w_emit;

    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;
    assign w_emit    = (r_state == S_EMIT) && !i_res_full;

    // sequencer: cross phase of six terms, then mass phase of three axes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_sub   <= '0;
            r_cmd   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd   <= i_cmd;
                        r_idx   <= '0;
                        r_sub   <= '0;
                        r_state <= i_cmd.counted ? S_CROSS : S_EMIT;
                    end
                end
                S_CROSS: begin
                    if (r_sub == SUB_CROSS_LAST) begin
                        r_sub <= '0;
                        if (r_idx == IDX_CROSS_LAST) begin
                            r_idx   <= '0;
                            r_state <= S_MASS;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end else begin
                        r_sub <= r_sub + 1'b1;
                    end
                end
                S_MASS: begin
                    if (r_sub == SUB_MASS_LAST) begin
                        r_sub <= '0;
                        if (r_idx == IDX_MASS_LAST) begin
                            r_idx   <= '0;
                            r_state <= S_DRAIN;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end else begin
                        r_sub <= r_sub + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_state <= r_cmd.last ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    if (!i_res_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // step decode: operand selection for the multiplier and the op for stage two
    always_comb begin
        sel_d    = r_cmd.d_y;
        sel_v    = r_cmd.v_x;
        s1_op    = OP_NOP;
        s1_shift = SH_NONE;
        s1_axis  = r_idx[1:0];
        s1_a     = '0;
        s1_b     = '0;
        case (r_idx)
            3'd0:    begin sel_d = r_cmd.d_y; sel_v = r_cmd.v_z; end
            3'd1:    begin sel_d = r_cmd.d_z; sel_v = r_cmd.v_y; end
            3'd2:    begin sel_d = r_cmd.d_z; sel_v = r_cmd.v_x; end
            3'd3:    begin sel_d = r_cmd.d_x; sel_v = r_cmd.v_z; end
            3'd4:    begin sel_d = r_cmd.d_x; sel_v = r_cmd.v_y; end
            default: begin sel_d = r_cmd.d_y; sel_v = r_cmd.v_x; end
        endcase
        case (r_idx[1:0])
            2'd0:    sel_c = r_c[0];
            2'd1:    sel_c = r_c[1];
            default: sel_c = r_c[2];
        endcase
        case (r_state)
            S_CROSS: begin
                // terms pair up: even term is the minuend, odd term closes the axis
                s1_axis = r_idx[2:1];
                s1_a    = MA'(sel_d);
                case (r_sub)
                    3'd0: begin
                        s1_op    = OP_LOAD;
                        s1_shift = SH_HALF;
                        s1_b     = MB'($signed(sel_v[FW-1:HW]));
                    end
                    3'd1: begin
                        s1_op = OP_ADD;
                        s1_b  = MB'({1'b0, sel_v[HW-1:0]});
                    end
                    default: begin
                        s1_op = r_idx[0] ? OP_C : OP_T1;
                    end
                endcase
            end
            S_MASS: begin
                // c split into signed high part and unsigned low half, mass in halves
                case (r_sub)
                    3'd0: begin
                        s1_op    = OP_LOAD;
                        s1_shift = SH_FULL;
                        s1_a     = MA'($signed(sel_c[CW-1:HW]));
                        s1_b     = MB'({1'b0, r_cmd.mass[FW-1:HW]});
                    end
                    3'd1: begin
                        s1_op    = OP_ADD;
                        s1_shift = SH_HALF;
                        s1_a     = MA'($signed(sel_c[CW-1:HW]));
                        s1_b     = MB'({1'b0, r_cmd.mass[HW-1:0]});
                    end
                    3'd2: begin
                        s1_op    = OP_ADD;
                        s1_shift = SH_HALF;
                        s1_a     = MA'({1'b0, sel_c[HW-1:0]});
                        s1_b     = MB'({1'b0, r_cmd.mass[FW-1:HW]});
                    end
                    3'd3: begin
                        s1_op = OP_ADD;
                        s1_a  = MA'({1'b0, sel_c[HW-1:0]});
                        s1_b  = MB'({1'b0, r_cmd.mass[HW-1:0]});
                    end
                    3'd4:    s1_op = OP_CLAMP;
                    default: s1_op = OP_SUM;
                endcase
            end
            default: begin
                s1_op = OP_NOP;
            end
        endcase
    end

    // stage two arithmetic: shift-add, floor by the fraction, clamps
    always_comb begin
        prod_ext = AW'(r_prod);
        case (r_shift)
            SH_HALF: prod_sh = prod_ext <<< HW;
            SH_FULL: prod_sh = prod_ext <<< (2 * HW);
            default: prod_sh = prod_ext;
        endcase
        acc_q  = r_acc >>> FRAC_BITS;
        q_hi   = acc_q[AW-1:ACC_WIDTH-1];
        q_fits = (&q_hi) || !(|q_hi);
        n_term = q_fits ? acc_q[ACC_WIDTH-1:0] : (acc_q[AW-1] ? ACC_MIN : ACC_MAX);
        n_c    = r_t1 - acc_q[CW-1:0];
        case (r_axis)
            2'd0:    sum_cur = r_sum[0];
            2'd1:    sum_cur = r_sum[1];
            default: sum_cur = r_sum[2];
        endcase
        sum_wide = {sum_cur[ACC_WIDTH-1], sum_cur} + {r_term[ACC_WIDTH-1], r_term};
        sum_ovf  = sum_wide[ACC_WIDTH] != sum_wide[ACC_WIDTH-1];
        n_sum    = sum_ovf ? (sum_wide[ACC_WIDTH] ? ACC_MIN : ACC_MAX)
                           : sum_wide[ACC_WIDTH-1:0];
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= s1_a * s1_b;
        case (r_op)
            OP_LOAD:  r_acc <= prod_sh;
            OP_ADD:   r_acc <= r_acc + prod_sh;
            OP_T1:    r_t1  <= acc_q[CW-1:0];
            OP_C:     r_c[r_axis] <= n_c;
            OP_CLAMP: r_term <= n_term;
            default:  r_acc <= r_acc;
        endcase
    end

    // stage tags, sums and the saturation flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op     <= OP_NOP;
            r_shift  <= SH_NONE;
            r_axis   <= '0;
            r_sum[0] <= '0;
            r_sum[1] <= '0;
            r_sum[2] <= '0;
            r_sat    <= 1'b0;
        end else begin
            r_op    <= s1_op;
            r_shift <= s1_shift;
            r_axis  <= s1_axis;
            if (w_emit) begin
                r_sum[0] <= '0;
                r_sum[1] <= '0;
                r_sum[2] <= '0;
                r_sat    <= 1'b0;
            end else begin
                case (r_op)
                    OP_CLAMP: begin
                        if (!q_fits) begin
                            r_sat <= 1'b1;
                        end
                    end
                    OP_SUM: begin
                        r_sum[r_axis] <= n_sum;
                        if (sum_ovf) begin
                            r_sat <= 1'b1;
                        end
                    end
                    default: begin
                        r_sat <= r_sat;
                    end
                endcase
            end
        end
    end

    // result: sums clamped to the output width
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            emit_se[k]   = EW'(r_sum[k]);
            emit_hi[k]   = emit_se[k][EW-1:OW-1];
            emit_clip[k] = !((&emit_hi[k]) || !(|emit_hi[k]));
            emit_val[k]  = emit_clip[k] ? (emit_se[k][EW-1] ? OUT_MIN : OUT_MAX)
                                        : emit_se[k][OW-1:0];
        end
        o_res.mom_x      = emit_val[0];
        o_res.mom_y      = emit_val[1];
        o_res.mom_z      = emit_val[2];
        o_res.overflowed = r_sat || (|emit_clip);
    end

    assign o_res_push = w_emit;

endmodule

`default_nettype wire

FILE: verif/angular_momentum_accumulator_top_test.sv
// Self-checking testbench for the angular momentum accumulator top level.
`default_nettype none

module angular_momentum_accumulator_top_test;

    localparam int FRAC = 16;
    localparam int ACC_W = 48;
    localparam int IDLE_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_OFF_CYCLES = 500;

    localparam logic signed [127:0] ACC_MAX = (128'sd1 <<< (ACC_W - 1)) - 128'sd1;
    localparam logic signed [127:0] ACC_MIN = -ACC_MAX - 128'sd1;
    localparam logic signed [127:0] OUT_MAX =
        (128'sd1 <<< (amacc_pkg::OUT_W - 1)) - 128'sd1;
    localparam logic signed [127:0] OUT_MIN = -OUT_MAX - 128'sd1;

    localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
    localparam logic [31:0] MINV = 32'h8000_0000;
    localparam logic [31:0] ALL1 = 32'hFFFF_FFFF;
    localparam logic [31:0] ONE  = 32'h0001_0000;

    typedef struct packed {
        logic [amacc_pkg::FIELD_W-1:0] pos_x;
        logic [amacc_pkg::FIELD_W-1:0] pos_y;
        logic [amacc_pkg::FIELD_W-1:0] pos_z;
        logic [amacc_pkg::FIELD_W-1:0] vel_x;
        logic [amacc_pkg::FIELD_W-1:0] vel_y;
        logic [amacc_pkg::FIELD_W-1:0] vel_z;
        logic [amacc_pkg::FIELD_W-1:0] mass;
        logic [amacc_pkg::FIELD_W-1:0] mask;
        logic                          last;
    } t_particle;

    typedef struct packed {
        logic [amacc_pkg::OUT_W-1:0] mom_x;
        logic [amacc_pkg::OUT_W-1:0] mom_y;
        logic [amacc_pkg::OUT_W-1:0] mom_z;
        logic                        ovf;
    } t_moment;

    // clock, reset and DUT-facing signals
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    logic        full, empty;
    t_particle   tx_item = '0;
    logic signed [amacc_pkg::OUT_W-1:0] o_momentum_x, o_momentum_y, o_momentum_z;
    logic        o_overflowed;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // shadow registers and running sums of the predictor
    logic [31:0] org_x = '0, org_y = '0, org_z = '0, grp_sel = 32'd1;
    logic signed [127:0] acc_x = '0, acc_y = '0, acc_z = '0;
    logic acc_ovf = 1'b0;

    t_particle particle_q[$];
    t_moment   expected_sums_q[$];

    // stimulus control and statistics
    bit   steady = 1'b0;
    int   hold_req = 0;
    int   hold_left = 0;
    int   gap_left = 0;
    int   burst_left = 0;
    logic [15:0] pop_pat = 16'hFFFF;
    logic [3:0]  pat_pos = '0;
    int   idle_cycles = 0;
    int   n_err = 0;
    int   n_particles = 0;
    int   n_sets = 0;
    int   n_ovf_sets = 0;
    int   n_full_cycles = 0;
    int   n_reg_writes = 0;

    angular_momentum_accumulator_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_pos_x         (tx_item.pos_x),
        .i_pos_y         (tx_item.pos_y),
        .i_pos_z         (tx_item.pos_z),
        .i_vel_x         (tx_item.vel_x),
        .i_vel_y         (tx_item.vel_y),
        .i_vel_z         (tx_item.vel_z),
        .i_particle_mass (tx_item.mass),
        .i_member_mask   (tx_item.mask),
        .i_last_particle (tx_item.last),
        .empty           (empty),
        .pop             (pop),
        .o_momentum_x    (o_momentum_x),
        .o_momentum_y    (o_momentum_y),
        .o_momentum_z    (o_momentum_z),
        .o_overflowed    (o_overflowed),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Predictor: exact wide arithmetic, floor after every shift
    // ---------------------------------------------------------------------
    function automatic logic signed [127:0] sx(input logic [31:0] v);
        return {{96{v[31]}}, v};
    endfunction

    // floor(a*b / 2^F) - floor(c*d / 2^F)
    function automatic logic signed [127:0] cross_q(input logic signed [127:0] a,
                                                    input logic signed [127:0] b,
                                                    input logic signed [127:0] c,
                                                    input logic signed [127:0] d);
        logic signed [127:0] p1, p2;
        p1 = a * b;
        p2 = c * d;
        return (p1 >>> FRAC) - (p2 >>> FRAC);
    endfunction

    // floor(mass * c / 2^F), clamped to the accumulator range
    function automatic logic signed [127:0] mass_scale(input logic [31:0] m,
                                                       input logic signed [127:0] c);
        logic signed [127:0] mm, q;
        mm = {96'd0, m};
        q = (mm * c) >>> FRAC;
        if (q > ACC_MAX) begin
            acc_ovf = 1'b1;
            q = ACC_MAX;
        end else if (q < ACC_MIN) begin
            acc_ovf = 1'b1;
            q = ACC_MIN;
        end
        return q;
    endfunction

    function automatic logic signed [127:0] sat_sum(input logic signed [127:0] s,
                                                    input logic signed [127:0] t);
        logic signed [127:0] r;
        r = s + t;
        if (r > ACC_MAX) begin
            acc_ovf = 1'b1;
            r = ACC_MAX;
        end else if (r < ACC_MIN) begin
            acc_ovf = 1'b1;
            r = ACC_MIN;
        end
        return r;
    endfunction

    // only bites when the accumulator is wider than the output
    function automatic logic [amacc_pkg::OUT_W-1:0] clip_out(input logic signed [127:0] s);
        logic signed [127:0] r;
        r = s;
        if (r > OUT_MAX) begin
            acc_ovf = 1'b1;
            r = OUT_MAX;
        end else if (r < OUT_MIN) begin
            acc_ovf = 1'b1;
            r = OUT_MIN;
        end
        return r[amacc_pkg::OUT_W-1:0];
    endfunction

    task automatic add_particle(input t_particle p);
        logic signed [127:0] dx, dy, dz, vx, vy, vz, m_x, m_y, m_z;
        t_moment res;
        if ((p.mask & grp_sel) != '0) begin
            dx = sx(p.pos_x) - sx(org_x);
            dy = sx(p.pos_y) - sx(org_y);
            dz = sx(p.pos_z) - sx(org_z);
            vx = sx(p.vel_x);
            vy = sx(p.vel_y);
            vz = sx(p.vel_z);
            m_x = mass_scale(p.mass, cross_q(dy, vz, dz, vy));
            m_y = mass_scale(p.mass, cross_q(dz, vx, dx, vz));
            m_z = mass_scale(p.mass, cross_q(dx, vy, dy, vx));
            acc_x = sat_sum(acc_x, m_x);
            acc_y = sat_sum(acc_y, m_y);
            acc_z = sat_sum(acc_z, m_z);
        end
        if (p.last) begin
            res.mom_x = clip_out(acc_x);
            res.mom_y = clip_out(acc_y);
            res.mom_z = clip_out(acc_z);
            res.ovf = acc_ovf;
            expected_sums_q.push_back(res);
            acc_x = '0;
            acc_y = '0;
            acc_z = '0;
            acc_ovf = 1'b0;
        end
    endtask

    // ---------------------------------------------------------------------
    // Particle driver: bursts with random gaps, holds while full
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                add_particle(tx_item);
                void'(particle_q.pop_front());
                n_particles++;
            end
            if (push && full) begin
                n_full_cycles++;
            end else if (gap_left > 0 && !steady) begin
                gap_left--;
                push <= 1'b0;
            end else if (particle_q.size() > 0) begin
                push <= 1'b1;
                tx_item <= particle_q[0];
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 20);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                push <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Result monitor and checker, with its own stall pattern
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_moment exp_sums;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_sums_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("ERROR: unexpected result x=%h y=%h z=%h ovf=%b",
                                 o_momentum_x, o_momentum_y, o_momentum_z, o_overflowed);
                end else begin
                    exp_sums = expected_sums_q.pop_front();
                    n_sets++;
                    if (exp_sums.ovf)
                        n_ovf_sets++;
                    if (o_momentum_x !== exp_sums.mom_x || o_momentum_y !== exp_sums.mom_y ||
                        o_momentum_z !== exp_sums.mom_z || o_overflowed !== exp_sums.ovf) begin
                        n_err++;
                        if (n_err <= 10) begin
                            $display("ERROR: set %0d expected x=%h y=%h z=%h ovf=%b", n_sets,
                                     exp_sums.mom_x, exp_sums.mom_y, exp_sums.mom_z,
                                     exp_sums.ovf);
                            $display("       got               x=%h y=%h z=%h ovf=%b",
                                     o_momentum_x, o_momentum_y, o_momentum_z, o_overflowed);
                        end
                    end
                end
            end
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                if (pat_pos == '0)
                    pop_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom());
                pop <= steady | pop_pat[pat_pos];
                pat_pos = pat_pos + 4'd1;
            end
        end
    end

    // watchdog: cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("ERROR: no transaction for %0d cycles", IDLE_LIMIT);
            $display("angular_momentum_accumulator_top_test: done, errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------
    task automatic write_reg(input amacc_pkg::t_reg_idx idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            amacc_pkg::REG_ORIGIN_X:     org_x = val;
            amacc_pkg::REG_ORIGIN_Y:     org_y = val;
            amacc_pkg::REG_ORIGIN_Z:     org_z = val;
            amacc_pkg::REG_GROUP_SELECT: grp_sel = val;
            default: ;
        endcase
        n_reg_writes++;
    endtask

    // wait until every particle is taken and every set has come back
    task automatic drain();
        while (particle_q.size() != 0 || expected_sums_q.size() != 0 || push)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic t_particle mk(input logic [31:0] px, py, pz, vx, vy, vz, m, msk,
                                     input logic lst);
        t_particle p;
        p = '{pos_x: px, pos_y: py, pos_z: pz, vel_x: vx, vel_y: vy, vel_z: vz,
              mass: m, mask: msk, last: lst};
        return p;
    endfunction

    function automatic logic [31:0] rnd_coord();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: return MAXV;
            1: return MINV;
            2, 3: begin
                v = $urandom_range(0, 32'h0003_FFFF);
                return $urandom_range(0, 1) ? -v : v;
            end
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] rnd_mass();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return ALL1;
            2, 3, 4, 5, 6: return $urandom_range(0, 32'h0004_0000);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] rnd_mask();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return ALL1;
            2: return $urandom() & ~grp_sel;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_particle rnd_particle(input logic lst);
        return mk(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                  rnd_coord(), rnd_mass(), rnd_mask(), lst);
    endfunction

    // random sets, mostly short, now and then long
    task automatic queue_sets(input int n_items);
        int len, cnt;
        cnt = 0;
        while (cnt < n_items) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
                particle_q.push_back(rnd_particle(i == len - 1));
            cnt += len;
        end
    endtask

    function automatic logic [31:0] rnd_origin();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return MAXV;
            2: return MINV;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] rnd_group();
        case ($urandom_range(0, 3))
            0: return ALL1;
            1: return 32'd1 << $urandom_range(0, 31);
            default: return $urandom() | 32'd1;
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------------
    initial begin
        t_particle p;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part, reset configuration: origin at zero, group bit 0
        particle_q.push_back(mk('0, '0, '0, '0, '0, '0, '0, 32'd1, 1'b1));
        particle_q.push_back(mk(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, ALL1, 32'd2, 1'b1));
        particle_q.push_back(mk(MAXV, '0, MINV, '0, MINV, MAXV, ALL1, 32'd1, 1'b1));
        particle_q.push_back(mk(MINV, MAXV, '0, MAXV, '0, MINV, ALL1, ALL1, 1'b1));
        // three large terms of one sign drive the sums into saturation
        for (int i = 0; i < 3; i++)
            particle_q.push_back(mk('0, MAXV, '0, '0, '0, MAXV, ONE, 32'd1, i == 2));
        for (int i = 0; i < 3; i++)
            particle_q.push_back(mk('0, MAXV, '0, '0, '0, MINV, ONE, 32'd1, i == 2));
        // floor rounding of tiny negative products
        particle_q.push_back(mk('0, 32'd1, '0, '0, '0, ALL1, 32'h0000_8000, 32'd1, 1'b1));
        // truncated positive, zero mass, then a last particle outside the group
        particle_q.push_back(mk('0, 32'd1, '0, '0, '0, 32'd1, 32'h0000_8000, 32'd1, 1'b0));
        particle_q.push_back(mk(MAXV, MAXV, MINV, MINV, MAXV, MAXV, '0, 32'd1, 1'b0));
        particle_q.push_back(mk(32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, ONE, '0, 1'b1));
        drain();

        // widest displacements: origin at one extreme, positions at the other
        write_reg(amacc_pkg::REG_ORIGIN_X, MINV);
        write_reg(amacc_pkg::REG_ORIGIN_Y, MINV);
        write_reg(amacc_pkg::REG_ORIGIN_Z, MINV);
        write_reg(amacc_pkg::REG_GROUP_SELECT, ALL1);
        @(negedge i_clk);
        particle_q.push_back(mk(MAXV, MAXV, MAXV, ONE, 32'hFFFF_0000, 32'h0003_0000, ONE,
                                32'h8000_0000, 1'b1));
        drain();
        write_reg(amacc_pkg::REG_ORIGIN_X, MAXV);
        write_reg(amacc_pkg::REG_ORIGIN_Y, MAXV);
        write_reg(amacc_pkg::REG_ORIGIN_Z, MAXV);
        @(negedge i_clk);
        particle_q.push_back(mk(MINV, MINV, MINV, 32'd1, MAXV, MINV, ALL1, 32'd1, 1'b1));
        drain();

        // empty group: nothing counts, sets still close with zeros
        write_reg(amacc_pkg::REG_GROUP_SELECT, '0);
        @(negedge i_clk);
        particle_q.push_back(rnd_particle(1'b0));
        p = rnd_particle(1'b1);
        p.mask = ALL1;
        particle_q.push_back(p);
        drain();

        // random phases, each under its own configuration
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(amacc_pkg::REG_ORIGIN_X, rnd_origin());
            write_reg(amacc_pkg::REG_ORIGIN_Y, rnd_origin());
            write_reg(amacc_pkg::REG_ORIGIN_Z, rnd_origin());
            write_reg(amacc_pkg::REG_GROUP_SELECT, rnd_group());
            @(negedge i_clk);
            steady = (ph == 2);
            if (ph == 5) begin
                // receiver holds off while one-particle sets pile up behind it
                hold_req = HOLD_OFF_CYCLES;
                for (int i = 0; i < 80; i++) begin
                    p = rnd_particle(1'b1);
                    if ($urandom_range(0, 3) != 0)
                        p.mask = $urandom() & ~grp_sel;
                    particle_q.push_back(p);
                end
            end
            queue_sets(220);
            drain();
            steady = 1'b0;
        end

        $display("summary: %0d particles in %0d sets checked, %0d sets flagged overflow",
                 n_particles, n_sets, n_ovf_sets);
        $display("summary: %0d register writes, input held back for %0d cycles, %0d sets missing",
                 n_reg_writes, n_full_cycles, expected_sums_q.size());
        if (n_err == 0 && expected_sums_q.size() == 0)
            $display("angular_momentum_accumulator_top_test: done, clean");
        else
            $display("angular_momentum_accumulator_top_test: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

FILE: angular_momentum_accumulator_top.f
sv/amacc_pkg.sv
sv/amacc_queue.sv
sv/amacc_front.sv
sv/amacc_back.sv
sv/angular_momentum_accumulator_top.sv
verif/angular_momentum_accumulator_top_test.sv
